// ----- rtl/core/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the polled serial tablet link host.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int REPORT_BYTES = 5;
  localparam int SETUP_LEN    = 5;
  localparam int QUEUE_DEPTH  = 4;

  localparam int OP_W     = 3;
  localparam int BIDX_W   = 3;
  localparam int RB_IDX_W = $clog2(REPORT_BYTES - 1);
  localparam int BEAT_W   = $clog2(SETUP_LEN);

  localparam logic [7:0] CMD_POLL_BYTE = 8'h50;
  localparam logic [7:0] CMD_STOP_BYTE = 8'h13;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 3'd0,
    OP_CLOSE = 3'd1,
    OP_POLL  = 3'd2,
    OP_BYTE  = 3'd3,
    OP_RXERR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CMD_SETUP  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_POLL   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  buttons;
    logic [13:0] x_pos;
    logic [13:0] y_pos;
  } cmd_t;

  function automatic logic [7:0] setup_byte(input logic [BEAT_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h20;
      3'd1:    b = 8'h00;
      3'd2:    b = 8'h44;
      3'd3:    b = 8'h62;
      3'd4:    b = 8'h11;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/stp_front.sv -----
// ----------------------------------------------------------------------------
// stp_front
// Accepts opcodes, tracks link and report collection state, and turns each
// opcode into at most one queued command for the output side.
// ----------------------------------------------------------------------------
module stp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       input_kind,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [stp_pkg::OP_W-1:0]   opcode,
  input  logic [7:0]                 rx_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output stp_pkg::cmd_t              q_data
);
  import stp_pkg::*;

  logic                link_open;
  logic                link_open_next;
  logic                awaiting;
  logic                awaiting_next;
  logic [BIDX_W-1:0]   byte_index;
  logic [BIDX_W-1:0]   byte_index_next;
  logic [7:0]          rb [REPORT_BYTES-1];
  logic                rb_wr;
  logic                accept;
  logic                has_cmd;
  logic                good;
  logic [1:0]          btn;
  logic [2:0]          hmask;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && has_cmd;

  // Report check: the final byte is checked straight from the input.
  always_comb begin
    good = rb[0][7] && !rx_byte[7];
    for (int i = 1; i < REPORT_BYTES - 1; i++) begin
      good = good && !rb[i][7];
    end
    hmask = rb[0][2:0];
    if (input_kind) begin
      if (hmask == 3'd0) begin
        btn = 2'd0;
      end else if (hmask inside {3'd1, 3'd2}) begin
        btn = 2'd1;
      end else begin
        btn = 2'd2;
      end
    end else begin
      btn = rb[0][1:0];
    end
  end

  always_comb begin
    link_open_next  = link_open;
    awaiting_next   = awaiting;
    byte_index_next = byte_index;
    rb_wr           = 1'b0;
    has_cmd         = 1'b0;
    q_data          = '0;
    q_data.kind     = CMD_SETUP;
    case (op_t'(opcode))
      OP_OPEN: begin
        link_open_next  = 1'b1;
        awaiting_next   = 1'b0;
        byte_index_next = '0;
        has_cmd         = 1'b1;
      end
      OP_CLOSE: begin
        awaiting_next   = 1'b0;
        byte_index_next = '0;
        link_open_next  = 1'b0;
        has_cmd         = link_open;
        q_data.kind     = CMD_STOP;
      end
      OP_POLL: begin
        awaiting_next   = 1'b1;
        byte_index_next = '0;
        has_cmd         = 1'b1;
        q_data.kind     = CMD_POLL;
      end
      OP_BYTE: begin
        if (awaiting) begin
          if (byte_index == BIDX_W'(REPORT_BYTES - 1)) begin
            awaiting_next   = 1'b0;
            byte_index_next = '0;
            has_cmd         = 1'b1;
            if (good) begin
              // Data bytes have clear MSBs, so the sums are plain joins.
              q_data.kind    = CMD_REPORT;
              q_data.buttons = btn;
              q_data.x_pos   = {rb[2][6:0], rb[1][6:0]};
              q_data.y_pos   = {rx_byte[6:0], rb[3][6:0]};
            end
          end else begin
            rb_wr           = 1'b1;
            byte_index_next = byte_index + 1'b1;
          end
        end
      end
      OP_RXERR: begin
        awaiting_next   = 1'b0;
        byte_index_next = '0;
        has_cmd         = 1'b1;
      end
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_open  <= 1'b0;
      awaiting   <= 1'b0;
      byte_index <= '0;
    end else if (accept) begin
      link_open  <= link_open_next;
      awaiting   <= awaiting_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rb_wr) begin
      rb[byte_index[RB_IDX_W-1:0]] <= rx_byte;
    end
  end

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !awaiting |-> byte_index == '0)
    else $error("byte index nonzero while no report is pending");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= BIDX_W'(REPORT_BYTES - 1))
    else $error("byte index beyond report length");

endmodule

// ----- rtl/core/stp_fifo.sv -----
// ----------------------------------------------------------------------------
// stp_fifo
// Short command queue between the opcode front end and the word emitter.
// ----------------------------------------------------------------------------
module stp_fifo #(
  parameter int DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output stp_pkg::cmd_t head
);
  import stp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full command queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/core/stp_back.sv -----
// ----------------------------------------------------------------------------
// stp_back
// Expands queued commands into output words and holds them in a registered
// output stage.
// ----------------------------------------------------------------------------
module stp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  stp_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          tx_valid,
  output logic [7:0]    tx_byte,
  output logic          report_valid,
  output logic [1:0]    buttons,
  output logic [13:0]   x_pos,
  output logic [13:0]   y_pos,
  output logic          last
);
  import stp_pkg::*;

  logic [BEAT_W-1:0] beat;
  logic              beat_last;
  logic              load;
  logic [7:0]        byte_sel;

  // The head entry stays in the queue until its final word is loaded.
  assign beat_last = (q_head.kind != CMD_SETUP) || (beat == BEAT_W'(SETUP_LEN - 1));
  assign load      = q_valid && (!out_valid || out_ready);
  assign q_pop     = load && beat_last;

  always_comb begin
    case (q_head.kind)
      CMD_SETUP:  byte_sel = setup_byte(beat);
      CMD_STOP:   byte_sel = CMD_STOP_BYTE;
      CMD_POLL:   byte_sel = CMD_POLL_BYTE;
      CMD_REPORT: byte_sel = 8'h00;
      default:    byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      beat      <= beat_last ? '0 : beat + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_valid     <= q_head.kind != CMD_REPORT;
      tx_byte      <= byte_sel;
      report_valid <= q_head.kind == CMD_REPORT;
      buttons      <= q_head.buttons;
      x_pos        <= q_head.x_pos;
      y_pos        <= q_head.y_pos;
      last         <= beat_last;
    end
  end

  a_beat_setup: assert property (@(posedge clk) disable iff (rst)
    beat != '0 |-> q_valid && q_head.kind == CMD_SETUP)
    else $error("setup sequence in progress without a setup entry at the head");

endmodule

// ----- rtl/core/serial_tablet_report_protocol.sv -----
// ----------------------------------------------------------------------------
// serial_tablet_report_protocol
// Host side of a polled serial tablet link: opcodes in, command bytes and
// decoded position reports out.
// ----------------------------------------------------------------------------
// An opcode word is accepted in every cycle in which the command queue
// (QUEUE_DEPTH entries) has room, so the input side takes one word per clock
// while the output side drains. Each queued command leaves through the
// registered output port: open, receive error and a bad report give five
// words, close while the link is open, poll and a good report give one word.
// The sustained rate is therefore set by the output port, one word per cycle
// while m_tready is high; received bytes that complete no report give no word.
module serial_tablet_report_protocol #(
  parameter int QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,      // input_kind: 0 stylus, 1 puck
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,        // [2:0] opcode, [10:3] rx_byte, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,        // [7:0] tx_byte, [9:8] buttons,
                                      // [23:10] x_pos, [37:24] y_pos, rest zero
  output logic [1:0]  m_tuser,        // [0] tx_valid, [1] report_valid
  output logic        m_tlast
);
  import stp_pkg::*;

  logic        input_kind;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_in;
  cmd_t        q_head;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        report_valid;
  logic [1:0]  buttons;
  logic [13:0] x_pos;
  logic [13:0] y_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_kind <= 1'b0;
    end else if (cfg_wen) begin
      input_kind <= cfg_wdata;
    end
  end

  stp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .input_kind (input_kind),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[OP_W-1:0]),
    .rx_byte    (s_tdata[10:3]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  stp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  stp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .report_valid (report_valid),
    .buttons      (buttons),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .last         (m_tlast)
  );

  assign m_tdata = {2'b00, y_pos, x_pos, buttons, tx_byte};
  assign m_tuser = {report_valid, tx_valid};

endmodule
